// ===== src/lrt_pkg.sv =====
package lrt_pkg;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_HIT     = 3'd1,
    ST_EVICTED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  localparam int unsigned OUT_KEY_BITS = 32;

  // request decoded once at the top and broadcast along the row
  typedef struct packed {
    logic en;
    logic evict;
    logic hit;
    logic add;
  } cell_cmd_t;

endpackage

// ===== src/lru_recency_tracker.sv =====
// LRU list of up to ENTRIES distinct keys, oldest first. Each beat on the
// input is a touch (append a new key unless full, or move a held key to the
// newest place) or an evict (remove and return the oldest key, if any), and
// gives exactly one result beat. Each cell of the row compares its key with
// the request in parallel and takes its neighbour's key in the same edge, so
// a new beat is taken every cycle while the result register is free or being
// drained. Result appears the cycle after acceptance.
module lru_recency_tracker
  import lrt_pkg::*;
#(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_evicted_key
);

  logic [KEY_BITS-1:0] req_key;
  logic [KEY_BITS-1:0] keys_w [0:ENTRIES];
  logic [ENTRIES:0]    valid_w;
  logic [ENTRIES:0]    pass_w;
  logic                accept;
  logic                empty;
  logic                full;
  logic                hit;
  cell_cmd_t           cmd;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic [OUT_KEY_BITS-1:0]  evk_r, evk_nxt;

  assign req_key = KEY_BITS'(in_key);
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  assign keys_w[ENTRIES]  = '0;
  assign valid_w[ENTRIES] = 1'b0;
  assign pass_w[0]        = 1'b0;

  assign empty = ~valid_w[0];
  assign full  = valid_w[ENTRIES-1];
  assign hit   = pass_w[ENTRIES];

  assign cmd.en    = accept;
  assign cmd.evict = in_req_type;
  assign cmd.hit   = ~in_req_type & hit;
  assign cmd.add   = ~in_req_type & ~hit & ~full;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic prev_v;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_rest
      assign prev_v = valid_w[i-1];
    end
    lrt_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .req_key    (req_key),
      .next_key   (keys_w[i+1]),
      .next_valid (valid_w[i+1]),
      .prev_valid (prev_v),
      .pass_in    (pass_w[i]),
      .key_o      (keys_w[i]),
      .valid_o    (valid_w[i]),
      .pass_out   (pass_w[i+1])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    evk_nxt       = evk_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      evk_nxt       = '0;
      if (in_req_type) begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_EVICTED;
          evk_nxt    = OUT_KEY_BITS'(keys_w[0]);
        end
      end else if (hit) begin
        status_nxt = ST_HIT;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ADDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    evk_r    <= evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_evicted_key = evk_r;

endmodule

// ===== src/lrt_cell.sv =====
module lrt_cell
  import lrt_pkg::*;
#(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [KEY_BITS-1:0] next_key,
  input  logic                next_valid,
  input  logic                prev_valid,
  input  logic                pass_in,
  output logic [KEY_BITS-1:0] key_o,
  output logic                valid_o,
  output logic                pass_out
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic                match;
  logic                newest;
  logic                slot;

  assign match    = valid_r && (key_r == req_key);
  assign pass_out = pass_in | match;
  assign newest   = valid_r & ~next_valid;
  // first free position
  assign slot     = ~valid_r & prev_valid;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      if (cmd.evict) begin
        key_nxt   = next_key;
        valid_nxt = next_valid;
      end else if (cmd.hit) begin
        // cells from the hit onwards move one towards the oldest end
        if (pass_out) begin
          key_nxt = newest ? req_key : next_key;
        end
      end else if (cmd.add && slot) begin
        key_nxt   = req_key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;

endmodule

// ===== src/lrt_checker.sv =====
module lrt_checker
  import lrt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_evicted_key
);

  // a result beat held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_evicted_key))
    else $error("result beat changed while stalled");

  // every accepted request shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accepted request");

  // a stalled result blocks new requests
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken over a pending result");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EVICTED |-> out_evicted_key == 32'd0)
    else $error("evicted key non-zero without eviction");

  // an evict request never reports a touch outcome
  a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=>
      out_status == ST_EVICTED || out_status == ST_EMPTY)
    else $error("evict request gave a touch status");

endmodule

bind lru_recency_tracker lrt_checker u_lrt_checker (.*);
